@@ sv/brt_pkg.sv @@
package brt_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int TARE_SAMPLES = 50;
   localparam int CMD_W        = 2;
   localparam int HALF_W       = 16;
   localparam int TICK_W       = 24;
   localparam int COEFF_W      = 32;
   localparam int WEIGHT_W     = 32;
   localparam int FRAC_BITS    = 40;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;

   localparam int BIT_CNT_W = $clog2(SAMPLE_BITS + 1);
   localparam int SCNT_W    = $clog2(TARE_SAMPLES + 1);
   localparam int TSUM_W    = SAMPLE_BITS + $clog2(TARE_SAMPLES);
   localparam int PROD_W    = SAMPLE_BITS + COEFF_W;

   // floor(sum / TARE_SAMPLES) as (sum * recip) >> DIV_SHIFT, exact over the sum range
   localparam int DIV_SHIFT = TSUM_W + SCNT_W;
   localparam int RECIP_W   = DIV_SHIFT - $clog2(TARE_SAMPLES) + 1;
   localparam logic [RECIP_W-1:0] TARE_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES));

   localparam logic [CMD_W-1:0] CMD_WEIGH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TARE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READY_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARE_GAP      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_COEFF   = 2'd3;

   localparam logic [HALF_W-1:0]  HALF_RST    = 16'd1;
   localparam logic [TICK_W-1:0]  TIMEOUT_RST = 24'd200000;
   localparam logic [TICK_W-1:0]  GAP_RST     = 24'd100000;
   localparam logic [COEFF_W-1:0] COEFF_RST   = 32'hFEB16918;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW,
      PH_XHIGH,
      PH_XLOW,
      PH_GAP
   } phase_type;

   typedef struct packed {
      logic [HALF_W-1:0]  half_period_ticks;
      logic [TICK_W-1:0]  ready_timeout_ticks;
      logic [TICK_W-1:0]  tare_gap_ticks;
      logic [COEFF_W-1:0] scale_coeff;
   } cfg_type;

   typedef struct packed {
      logic                   clock_pin;
      logic                   busy;
      logic                   done;
      logic                   kind;
      logic                   timed_out;
      logic [SAMPLE_BITS-1:0] sample;
      logic [TSUM_W-1:0]      tare_sum;
   } seq_beat_type;

   typedef struct packed {
      logic                   clock_pin;
      logic                   busy;
      logic                   done;
      logic                   kind;
      logic                   timed_out;
      logic                   dneg;
      logic [SAMPLE_BITS-1:0] dmag;
      logic [SAMPLE_BITS-1:0] tare_level;
   } tare_beat_type;

   typedef struct packed {
      logic                   clock_pin;
      logic                   busy_res;
      logic                   done_res;
      logic                   done_kind;
      logic                   timed_out;
      logic [WEIGHT_W-1:0]    weight_mg;
      logic [SAMPLE_BITS-1:0] tare_level;
   } rsp_beat_type;

endpackage

@@ sv/brt_seq.sv @@
module brt_seq
   import brt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [CMD_W-1:0] command,
   input  logic             data_pin,
   output logic             out_valid,
   input  logic             out_ready,
   output seq_beat_type     out_beat
);

   phase_type              phase_ff, phase_in;
   logic                   op_is_tare_ff, op_is_tare_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [BIT_CNT_W-1:0]   bit_ff, bit_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic [SCNT_W-1:0]      scount_ff, scount_in;
   logic [TSUM_W-1:0]      tsum_ff, tsum_in;
   logic                   tseen_ff, tseen_in;
   logic                   valid_ff, valid_in;
   seq_beat_type           beat_ff, beat_in;

   logic                   accept;
   logic [TICK_W-1:0]      tick_inc;
   logic [HALF_W-1:0]      half_len;
   logic                   fin;
   logic                   gap_end;
   logic [SAMPLE_BITS-1:0] fin_val;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   assign tick_inc = tick_ff + 1'b1;
   assign half_len = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;

   always_comb begin
      phase_in      = phase_ff;
      op_is_tare_in = op_is_tare_ff;
      tick_in       = tick_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      scount_in     = scount_ff;
      tsum_in       = tsum_ff;
      tseen_in      = tseen_ff;
      fin           = 1'b0;
      gap_end       = 1'b0;
      fin_val       = '0;
      beat_in       = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (command == CMD_WEIGH || command == CMD_TARE) begin
               op_is_tare_in = (command == CMD_TARE);
               phase_in      = PH_WAIT;
               tick_in       = '0;
               scount_in     = '0;
               tsum_in       = '0;
               tseen_in      = 1'b0;
            end
         end
         PH_WAIT: begin
            if (!data_pin) begin
               phase_in = PH_HIGH;
               tick_in  = '0;
               bit_in   = '0;
               shift_in = '0;
            end else if (tick_ff >= cfg.ready_timeout_ticks) begin
               tseen_in = 1'b1;
               fin      = 1'b1;
            end else begin
               tick_in = tick_inc;
            end
         end
         PH_HIGH, PH_XHIGH: begin
            beat_in.clock_pin = 1'b1;
            tick_in           = tick_inc;
            if (tick_inc >= TICK_W'(half_len)) begin
               phase_in = (phase_ff == PH_HIGH) ? PH_LOW : PH_XLOW;
               tick_in  = '0;
            end
         end
         PH_LOW: begin
            tick_in = tick_inc;
            if (tick_inc >= TICK_W'(half_len)) begin
               shift_in = {shift_ff[SAMPLE_BITS-2:0], data_pin};
               bit_in   = bit_ff + 1'b1;
               tick_in  = '0;
               phase_in = (bit_in >= BIT_CNT_W'(SAMPLE_BITS)) ? PH_XHIGH : PH_HIGH;
            end
         end
         PH_XLOW: begin
            tick_in = tick_inc;
            if (tick_inc >= TICK_W'(half_len)) begin
               tick_in = '0;
               fin     = 1'b1;
               fin_val = shift_ff ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end
         end
         PH_GAP: begin
            tick_in = tick_inc;
            if (tick_inc >= cfg.tare_gap_ticks) begin
               gap_end = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // end of one sample
      if (fin) begin
         if (!op_is_tare_ff) begin
            beat_in.done      = 1'b1;
            beat_in.kind      = 1'b0;
            beat_in.timed_out = tseen_in;
            beat_in.sample    = fin_val;
            phase_in          = PH_IDLE;
         end else begin
            tsum_in   = tsum_ff + TSUM_W'(fin_val);
            scount_in = scount_ff + 1'b1;
            if (cfg.tare_gap_ticks != '0) begin
               phase_in = PH_GAP;
               tick_in  = '0;
            end else begin
               gap_end = 1'b1;
            end
         end
      end

      if (gap_end) begin
         if (scount_in >= SCNT_W'(TARE_SAMPLES)) begin
            beat_in.done      = 1'b1;
            beat_in.kind      = 1'b1;
            beat_in.timed_out = tseen_in;
            beat_in.tare_sum  = tsum_in;
            phase_in          = PH_IDLE;
         end else begin
            phase_in = PH_WAIT;
            tick_in  = '0;
         end
      end

      beat_in.busy = (phase_in != PH_IDLE);
      valid_in     = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         op_is_tare_ff <= 1'b0;
         tick_ff       <= '0;
         bit_ff        <= '0;
         shift_ff      <= '0;
         scount_ff     <= '0;
         tsum_ff       <= '0;
         tseen_ff      <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            op_is_tare_ff <= op_is_tare_in;
            tick_ff       <= tick_in;
            bit_ff        <= bit_in;
            shift_ff      <= shift_in;
            scount_ff     <= scount_in;
            tsum_ff       <= tsum_in;
            tseen_ff      <= tseen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= beat_in;
      end
   end

endmodule

@@ sv/brt_tare.sv @@
module brt_tare
   import brt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  seq_beat_type  in_beat,
   output logic          out_valid,
   input  logic          out_ready,
   output tare_beat_type out_beat
);

   logic [SAMPLE_BITS-1:0]    tare_store_ff, tare_store_in;
   logic                      valid_ff, valid_in;
   tare_beat_type             beat_ff, beat_in;

   logic                      accept;
   logic [TSUM_W+RECIP_W-1:0] quot_prod;
   logic [SAMPLE_BITS-1:0]    quot;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   // average of the tare samples by reciprocal multiply
   assign quot_prod = {{RECIP_W{1'b0}}, in_beat.tare_sum} * {{TSUM_W{1'b0}}, TARE_RECIP};
   assign quot      = quot_prod[DIV_SHIFT +: SAMPLE_BITS];

   always_comb begin
      tare_store_in     = tare_store_ff;
      beat_in           = '0;
      beat_in.clock_pin = in_beat.clock_pin;
      beat_in.busy      = in_beat.busy;
      beat_in.done      = in_beat.done;
      beat_in.kind      = in_beat.kind;
      beat_in.timed_out = in_beat.timed_out;
      if (in_beat.done && in_beat.kind) begin
         tare_store_in = quot;
      end
      if (in_beat.done && !in_beat.kind) begin
         if (in_beat.sample >= tare_store_ff) begin
            beat_in.dmag = in_beat.sample - tare_store_ff;
            beat_in.dneg = 1'b0;
         end else begin
            beat_in.dmag = tare_store_ff - in_beat.sample;
            beat_in.dneg = 1'b1;
         end
      end
      beat_in.tare_level = tare_store_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tare_store_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            tare_store_ff <= tare_store_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= beat_in;
      end
   end

endmodule

@@ sv/brt_scale.sv @@
module brt_scale
   import brt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COEFF_W-1:0] scale_coeff,
   input  logic               in_valid,
   output logic               in_ready,
   input  tare_beat_type      in_beat,
   output logic               out_valid,
   input  logic               out_ready,
   output rsp_beat_type       out_beat
);

   localparam int SAT_W = WEIGHT_W + 1;
   localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(1) << (WEIGHT_W - 1);
   localparam logic [SAT_W-1:0] POS_LIM = NEG_LIM - 1'b1;

   typedef struct packed {
      logic                   clock_pin;
      logic                   busy;
      logic                   done;
      logic                   kind;
      logic                   timed_out;
      logic                   neg;
      logic [PROD_W-1:0]      prod;
      logic [SAMPLE_BITS-1:0] tare_level;
   } mul_beat_type;

   logic               mvalid_ff, mvalid_in;
   mul_beat_type       mbeat_ff, mbeat_in;
   logic               ovalid_ff, ovalid_in;
   rsp_beat_type       obeat_ff, obeat_in;

   logic               m_ready;
   logic               m_accept;
   logic               o_accept;
   logic [COEFF_W-1:0] cmag;
   logic [SAT_W-1:0]   qx;
   logic [SAT_W-1:0]   qs;

   // multiply stage
   assign m_ready   = !ovalid_ff || out_ready;
   assign in_ready  = !mvalid_ff || m_ready;
   assign m_accept  = in_valid && in_ready;
   assign mvalid_in = in_ready ? in_valid : mvalid_ff;

   assign cmag = scale_coeff[COEFF_W-1] ? ({COEFF_W{1'b0}} - scale_coeff) : scale_coeff;

   always_comb begin
      mbeat_in.clock_pin  = in_beat.clock_pin;
      mbeat_in.busy       = in_beat.busy;
      mbeat_in.done       = in_beat.done;
      mbeat_in.kind       = in_beat.kind;
      mbeat_in.timed_out  = in_beat.timed_out;
      mbeat_in.neg        = in_beat.dneg ^ scale_coeff[COEFF_W-1];
      mbeat_in.prod       = {{COEFF_W{1'b0}}, in_beat.dmag} * {{SAMPLE_BITS{1'b0}}, cmag};
      mbeat_in.tare_level = in_beat.tare_level;
   end

   // truncate toward zero, saturate, apply sign
   assign o_accept  = mvalid_ff && m_ready;
   assign ovalid_in = m_ready ? mvalid_ff : ovalid_ff;
   assign qx        = SAT_W'(mbeat_ff.prod[PROD_W-1:FRAC_BITS]);

   always_comb begin
      obeat_in.clock_pin  = mbeat_ff.clock_pin;
      obeat_in.busy_res   = mbeat_ff.busy;
      obeat_in.done_res   = mbeat_ff.done;
      obeat_in.done_kind  = mbeat_ff.kind;
      obeat_in.timed_out  = mbeat_ff.timed_out;
      obeat_in.tare_level = mbeat_ff.tare_level;
      if (mbeat_ff.neg) begin
         qs = (qx > NEG_LIM) ? NEG_LIM : qx;
         qs = {SAT_W{1'b0}} - qs;
      end else begin
         qs = (qx > POS_LIM) ? POS_LIM : qx;
      end
      obeat_in.weight_mg = (mbeat_ff.done && !mbeat_ff.kind) ? qs[WEIGHT_W-1:0] : '0;
   end

   assign out_valid = ovalid_ff;
   assign out_beat  = obeat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         mvalid_ff <= mvalid_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_accept) begin
         mbeat_ff <= mbeat_in;
      end
      if (o_accept) begin
         obeat_ff <= obeat_in;
      end
   end

endmodule

@@ sv/bridge_adc_reader_with_tare_top.sv @@
// throughput: one request beat and one result beat per cycle while rsp_tready holds no stall, one result per request
// the stages are sequencer, tare average and difference, multiply, saturate and output
// each stage holds when the stage after it is full and stalled
// synchronous reset: sequencer idle, tare zero, configuration registers to their default values
module bridge_adc_reader_with_tare_top
   import brt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // command[1:0], data_pin[2], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // clock_pin[0], busy_res[1], done_res[2],
                                              // timed_out[3], weight_mg[35:4],
                                              // tare_level[59:36], zero pad
   output logic                  rsp_tuser,   // done_kind
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;

   logic          s1_valid;
   logic          s1_ready;
   seq_beat_type  s1_beat;
   logic          s2_valid;
   logic          s2_ready;
   tare_beat_type s2_beat;
   rsp_beat_type  rsp_beat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HALF_PERIOD:   cfg_in.half_period_ticks   = csr_wdata[HALF_W-1:0];
            CSR_READY_TIMEOUT: cfg_in.ready_timeout_ticks = csr_wdata[TICK_W-1:0];
            CSR_TARE_GAP:      cfg_in.tare_gap_ticks      = csr_wdata[TICK_W-1:0];
            CSR_SCALE_COEFF:   cfg_in.scale_coeff         = csr_wdata[COEFF_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks   <= HALF_RST;
         cfg_ff.ready_timeout_ticks <= TIMEOUT_RST;
         cfg_ff.tare_gap_ticks      <= GAP_RST;
         cfg_ff.scale_coeff         <= COEFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   brt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .command   (req_tdata[CMD_W-1:0]),
      .data_pin  (req_tdata[CMD_W]),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_beat  (s1_beat)
   );

   brt_tare u_tare (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_beat   (s1_beat),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_beat  (s2_beat)
   );

   brt_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .scale_coeff (cfg_ff.scale_coeff),
      .in_valid    (s2_valid),
      .in_ready    (s2_ready),
      .in_beat     (s2_beat),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_beat    (rsp_beat)
   );

   assign rsp_tdata = {4'b0000, rsp_beat.tare_level, rsp_beat.weight_mg, rsp_beat.timed_out,
                       rsp_beat.done_res, rsp_beat.busy_res, rsp_beat.clock_pin};
   assign rsp_tuser = rsp_beat.done_kind;

endmodule

@@ verif/tb.sv @@
module tb;
   import brt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int               NEVER_READY = 1 << 30;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [63:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bridge_adc_reader_with_tare_top dut (.*);

   always #5 clock = ~clock;

   // register copies
   logic [HALF_W-1:0]  half_cfg    = HALF_RST;
   logic [TICK_W-1:0]  timeout_cfg = TIMEOUT_RST;
   logic [TICK_W-1:0]  gap_cfg     = GAP_RST;
   logic [COEFF_W-1:0] coeff_cfg   = COEFF_RST;

   // reader state
   phase_type              rd_phase   = PH_IDLE;
   logic                   rd_tare_op = 1'b0;
   logic [TICK_W-1:0]      rd_ticks   = '0;
   logic [BIT_CNT_W-1:0]   rd_bits    = '0;
   logic [SAMPLE_BITS-1:0] rd_shift   = '0;
   logic [SCNT_W-1:0]      rd_samples = '0;
   logic [TSUM_W-1:0]      rd_sum     = '0;
   logic [SAMPLE_BITS-1:0] rd_tare    = '0;
   logic                   rd_timeout = 1'b0;
   rsp_beat_type           rd_out;

   rsp_beat_type pending_readings[$];

   // stimulus knobs
   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   int                     hold_request  = 0;
   int                     hold_left     = 0;
   int                     delay_lo      = 0;
   int                     delay_hi      = 3;
   int                     wait_delay    = 0;
   int                     reads_left    = -1;
   logic                   use_fixed_raw = 1'b0;
   logic [SAMPLE_BITS-1:0] raw_word      = '0;

   int mismatches    = 0;
   int ticks_sent    = 0;
   int weighs_done   = 0;
   int tares_done    = 0;
   int late_ops      = 0;
   int reg_writes    = 0;

   function automatic logic [TICK_W-1:0] half_ticks();
      return (half_cfg == '0) ? TICK_W'(1) : TICK_W'(half_cfg);
   endfunction

   function automatic logic [WEIGHT_W-1:0] weight_from_sample(logic [SAMPLE_BITS-1:0] smp);
      logic [63:0] dmag, cmag, q;
      logic        dneg, cneg;
      dneg = smp < rd_tare;
      dmag = dneg ? 64'(rd_tare - smp) : 64'(smp - rd_tare);
      cneg = coeff_cfg[COEFF_W-1];
      cmag = cneg ? (64'h1_0000_0000 - 64'(coeff_cfg)) : 64'(coeff_cfg);
      q = (dmag * cmag) >> FRAC_BITS;
      if (dneg != cneg) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return WEIGHT_W'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return WEIGHT_W'(q);
   endfunction

   function automatic void end_tare_gap();
      if (rd_samples >= TARE_SAMPLES) begin
         rd_tare = SAMPLE_BITS'(rd_sum / TARE_SAMPLES);
         rd_out.done_res = 1'b1;
         rd_out.done_kind = 1'b1;
         rd_out.timed_out = rd_timeout;
         rd_phase = PH_IDLE;
      end else begin
         rd_phase = PH_WAIT;
         rd_ticks = '0;
      end
   endfunction

   function automatic void store_sample(logic [SAMPLE_BITS-1:0] smp);
      if (!rd_tare_op) begin
         rd_out.done_res = 1'b1;
         rd_out.done_kind = 1'b0;
         rd_out.timed_out = rd_timeout;
         rd_out.weight_mg = weight_from_sample(smp);
         rd_phase = PH_IDLE;
         return;
      end
      rd_sum = rd_sum + TSUM_W'(smp);
      rd_samples++;
      if (gap_cfg != '0) begin
         rd_phase = PH_GAP;
         rd_ticks = '0;
      end else begin
         end_tare_gap();
      end
   endfunction

   function automatic rsp_beat_type reader_tick(logic [CMD_W-1:0] cmd, logic pin);
      rd_out = '0;
      case (rd_phase)
         PH_IDLE: begin
            if (cmd == CMD_WEIGH || cmd == CMD_TARE) begin
               rd_tare_op = (cmd == CMD_TARE);
               rd_phase = PH_WAIT;
               rd_ticks = '0;
               rd_samples = '0;
               rd_sum = '0;
               rd_timeout = 1'b0;
            end
         end
         PH_WAIT: begin
            if (!pin) begin
               rd_phase = PH_HIGH;
               rd_ticks = '0;
               rd_bits = '0;
               rd_shift = '0;
            end else if (rd_ticks >= timeout_cfg) begin
               rd_timeout = 1'b1;
               store_sample('0);
            end else begin
               rd_ticks++;
            end
         end
         PH_HIGH, PH_XHIGH: begin
            rd_out.clock_pin = 1'b1;
            rd_ticks++;
            if (rd_ticks >= half_ticks()) begin
               rd_phase = (rd_phase == PH_HIGH) ? PH_LOW : PH_XLOW;
               rd_ticks = '0;
            end
         end
         PH_LOW: begin
            rd_ticks++;
            if (rd_ticks >= half_ticks()) begin
               rd_shift = {rd_shift[SAMPLE_BITS-2:0], pin};
               rd_bits++;
               rd_ticks = '0;
               rd_phase = (rd_bits >= SAMPLE_BITS) ? PH_XHIGH : PH_HIGH;
            end
         end
         PH_XLOW: begin
            rd_ticks++;
            if (rd_ticks >= half_ticks()) begin
               rd_ticks = '0;
               store_sample({~rd_shift[SAMPLE_BITS-1], rd_shift[SAMPLE_BITS-2:0]});
            end
         end
         PH_GAP: begin
            rd_ticks++;
            if (rd_ticks >= gap_cfg) end_tare_gap();
         end
         default: rd_phase = PH_IDLE;
      endcase
      rd_out.busy_res = (rd_phase != PH_IDLE);
      rd_out.tare_level = rd_tare;
      if (rd_out.done_res) begin
         if (rd_out.done_kind) tares_done++;
         else weighs_done++;
         if (rd_out.timed_out) late_ops++;
      end
      return rd_out;
   endfunction

   // converter behavior: ready after a random delay, then the chosen word bit by bit
   function automatic logic next_pin();
      case (rd_phase)
         PH_WAIT: begin
            if (rd_ticks == '0) begin
               wait_delay = $urandom_range(delay_hi, delay_lo);
               if (reads_left == 0) wait_delay = NEVER_READY;
               else if (reads_left > 0) reads_left--;
               if (!use_fixed_raw) raw_word = SAMPLE_BITS'($urandom);
            end
            return rd_ticks < wait_delay;
         end
         PH_LOW: begin
            if (rd_ticks + 1 >= half_ticks()) return raw_word[SAMPLE_BITS-1-rd_bits];
            return 1'($urandom_range(1));
         end
         default: return 1'($urandom_range(1));
      endcase
   endfunction

   task send_tick(input logic [CMD_W-1:0] cmd, input logic pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, pin, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_readings.push_back(reader_tick(cmd, pin));
      ticks_sent++;
   endtask

   task quiesce();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_HALF_PERIOD:   half_cfg = val[HALF_W-1:0];
         CSR_READY_TIMEOUT: timeout_cfg = val[TICK_W-1:0];
         CSR_TARE_GAP:      gap_cfg = val[TICK_W-1:0];
         CSR_SCALE_COEFF:   coeff_cfg = val[COEFF_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task configure(input logic [HALF_W-1:0] half, input logic [TICK_W-1:0] timeout,
                  input logic [TICK_W-1:0] gap, input logic [COEFF_W-1:0] coeff);
      quiesce();
      write_reg(CSR_HALF_PERIOD, CSR_DATA_W'(half));
      write_reg(CSR_READY_TIMEOUT, CSR_DATA_W'(timeout));
      write_reg(CSR_TARE_GAP, CSR_DATA_W'(gap));
      write_reg(CSR_SCALE_COEFF, coeff);
   endtask

   task run_op(input logic [CMD_W-1:0] op_cmd);
      send_tick(op_cmd, 1'($urandom_range(1)));
      while (rd_phase != PH_IDLE) send_tick(CMD_W'($urandom_range(3)), next_pin());
   endtask

   task run_fixed(input logic [CMD_W-1:0] op_cmd, input logic [SAMPLE_BITS-1:0] raw);
      use_fixed_raw = 1'b1;
      raw_word = raw;
      run_op(op_cmd);
      use_fixed_raw = 1'b0;
   endtask

   task test_idle_ticks();
      send_tick(CMD_TICK, 1'b0);
      send_tick(CMD_TICK, 1'b1);
      send_tick(CMD_UNKNOWN, 1'b0);
      send_tick(CMD_UNKNOWN, 1'b1);
   endtask

   task test_weigh_extremes();
      delay_lo = 0;
      delay_hi = 3;
      configure(HALF_RST, TIMEOUT_RST, GAP_RST, 32'h8000_0000);
      run_fixed(CMD_WEIGH, 24'h000000);
      configure(HALF_RST, TIMEOUT_RST, GAP_RST, 32'h7FFF_FFFF);
      run_fixed(CMD_WEIGH, 24'hFFFFFF);
   endtask

   task test_timeouts();
      // zero timeout with the pin held high
      configure(16'd1, 24'd0, GAP_RST, COEFF_RST);
      delay_lo = 1;
      delay_hi = 5;
      run_op(CMD_WEIGH);
      // ready exactly at the limit, zero half period acts as one
      configure(16'd0, 24'd5, GAP_RST, COEFF_RST);
      delay_lo = 5;
      delay_hi = 5;
      run_op(CMD_WEIGH);
      // one tick late
      delay_lo = 6;
      delay_hi = 6;
      run_op(CMD_WEIGH);
      // full-scale half period and gap, only reachable through a timeout here
      configure(16'hFFFF, 24'd0, 24'hFFFFFF, 32'h7FFF_FFFF);
      delay_lo = 1;
      delay_hi = 3;
      run_op(CMD_WEIGH);
   endtask

   task test_tare();
      // every sample times out, gap after each
      configure(16'd1, 24'd0, 24'd1, COEFF_RST);
      delay_lo = 1;
      delay_hi = 3;
      run_op(CMD_TARE);
      // two samples read, the rest time out, no gap
      configure(16'd1, 24'd0, 24'd0, COEFF_RST);
      delay_lo = 0;
      delay_hi = 0;
      reads_left = 2;
      run_op(CMD_TARE);
      reads_left = -1;
   endtask

   task test_backpressure();
      configure(16'd1, 24'd0, 24'd1, COEFF_RST);
      delay_lo = 1;
      delay_hi = 3;
      hold_request = 400;
      repeat (5) run_op(CMD_WEIGH);
      quiesce();
   endtask

   task test_random(input int snd_pct, input int rcv_pct, input int tick_budget);
      int stop_at;
      stop_at = ticks_sent + tick_budget;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(3) == 0)
            configure(HALF_W'($urandom_range(1)), TICK_W'($urandom_range(3)),
                      TICK_W'($urandom_range(2)), $urandom);
         delay_lo = 0;
         delay_hi = $urandom_range(6);
         case ($urandom_range(2))
            0: repeat ($urandom_range(6, 1))
               send_tick($urandom_range(1) ? CMD_UNKNOWN : CMD_TICK, 1'($urandom_range(1)));
            default: run_op(CMD_WEIGH);
         endcase
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.clock_pin = rsp_tdata[0];
         got.busy_res = rsp_tdata[1];
         got.done_res = rsp_tdata[2];
         got.done_kind = rsp_tuser;
         got.timed_out = rsp_tdata[3];
         got.weight_mg = rsp_tdata[35:4];
         got.tare_level = rsp_tdata[59:36];
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result beat with nothing pending: %h", rsp_tdata);
         end else begin
            want = pending_readings.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %b%b%b%b%b %0d %h got %b%b%b%b%b %0d %h",
                     want.clock_pin, want.busy_res, want.done_res, want.done_kind,
                     want.timed_out, $signed(want.weight_mg), want.tare_level,
                     got.clock_pin, got.busy_res, got.done_res, got.done_kind,
                     got.timed_out, $signed(got.weight_mg), got.tare_level);
            end
         end
      end
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 10;
      recv_idle_pct = 45;
      test_idle_ticks();
      test_weigh_extremes();
      test_timeouts();
      test_tare();
      test_backpressure();
      test_random(10, 45, 20);
      test_random(45, 10, 20);
      test_random(0, 0, 20);
      quiesce();
      $display("%0d ticks: %0d weighs, %0d tares, %0d operations with a timed-out sample",
               ticks_sent, weighs_done, tares_done, late_ops);
      $display("%0d register writes incl. zero and full-scale values, %0d mismatches",
               reg_writes, mismatches);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
